// ----- rtl/cpe_pkg.sv -----
// Shared types, constants and letter classification for the Cologne phonetic encoder.
`timescale 1ns / 1ps
`default_nettype none
package cpe_pkg;

  localparam logic [3:0] SymHmark = 4'd9;
  localparam logic [3:0] SymNone  = 4'd15;
  localparam logic [7:0] SpaceChr = 8'h20;
  localparam int unsigned JobSyms = 4;
  localparam int unsigned FifoDepth = 2;

  // Raw symbols of one byte: up to two.
  typedef struct packed {
    logic [1:0] cnt;
    logic [3:0] s0;
    logic [3:0] s1;
  } raw_t;

  // One request worth of raw symbols, handed from front to back.
  typedef struct packed {
    logic [JobSyms-1:0][3:0] sym;
    logic [2:0]              cnt;
    logic                    word_end;
  } job_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h61:8'h7a]}) r = b - 8'd32;
    return r;
  endfunction

  function automatic raw_t raw_syms(input logic [7:0] p, input logic [7:0] c,
                                    input logic [7:0] n, input logic first);
    raw_t r;
    r = '{cnt: 2'd1, s0: 4'd0, s1: 4'd0};
    if (first && c == "C") begin
      r.s0 = (n inside {"A", "H", "K", "L", "O", "Q", "R", "U", "X"}) ? 4'd4 : 4'd8;
    end else if (c == "P" && n == "H") begin
      r.s0 = 4'd3;
    end else if (c inside {"D", "T"}) begin
      r.s0 = (n inside {"S", "C", "Z"}) ? 4'd8 : 4'd2;
    end else if (c == "X") begin
      if (p inside {"C", "K", "Q"}) begin
        r.s0 = 4'd8;
      end else begin
        r.cnt = 2'd2;
        r.s0  = 4'd4;
        r.s1  = 4'd8;
      end
    end else if (c == "C") begin
      if (p inside {"S", "Z"}) r.s0 = 4'd8;
      else r.s0 = (n inside {"A", "O", "U", "H", "K", "X", "Q"}) ? 4'd4 : 4'd8;
    end else if (c == "H") begin
      r.s0 = SymHmark;
    end else if (c inside {"A", "E", "I", "J", "Y", "O", "U"}) begin
      r.s0 = 4'd0;
    end else if (c inside {"B", "P"}) begin
      r.s0 = 4'd1;
    end else if (c inside {"F", "V", "W"}) begin
      r.s0 = 4'd3;
    end else if (c inside {"G", "K", "Q"}) begin
      r.s0 = 4'd4;
    end else if (c == "L") begin
      r.s0 = 4'd5;
    end else if (c == "R") begin
      r.s0 = 4'd7;
    end else if (c inside {"M", "N"}) begin
      r.s0 = 4'd6;
    end else if (c inside {"S", "Z"}) begin
      r.s0 = 4'd8;
    end else begin
      r.cnt = 2'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cologne_phonetic_encoder_core.sv -----
// Cologne phonetic encoder: streams word bytes in, Cologne code digits out.
//
// Input channel (in_valid_i / in_stall_o): one byte per request, word_end_i
// set on the last byte of a word. A byte is taken every cycle while the
// two-entry job queue has room; the front end codes each byte once its
// successor arrives or the byte ends a word, in the job of that request.
// Output channel (out_valid_o / out_stall_i): one digit per request, with
// word_done_o on the last one of a word. A word end with no digit gives one
// request with digit_valid_o low and word_done_o high.
// Path: a job's digits pass through the queue, the back end's digit buffer
// and the output register. Throughput: one output request per cycle while
// the receiver does not stall, set by the single output register; a byte
// gives up to two digits (X gives 48), a word end's job up to four.
// Reset clears the look-back state, the queue and the collapse history.
// When the receiver stalls, the output register holds, the back end's
// buffer stops draining, the queue fills and in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none
module cologne_phonetic_encoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] letter_i,
  input  wire logic       word_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [3:0]      code_digit_o,
  output logic            digit_valid_o,
  output logic            word_done_o
);
  import cpe_pkg::*;

  job_t push_job, pop_job;
  logic push, full, job_valid, pop;

  cpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .letter_i   (letter_i),
    .word_end_i (word_end_i),
    .job_full_i (full),
    .job_push_o (push),
    .job_o      (push_job)
  );

  cpe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .valid_o     (job_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_job)
  );

  cpe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (pop_job),
    .job_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_digit_o  (code_digit_o),
    .digit_valid_o (digit_valid_o),
    .word_done_o   (word_done_o)
  );

`ifndef SYNTH
  // an empty item only ever closes a word
  a_blank_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !digit_valid_o) |-> (word_done_o && code_digit_o == 4'd0))
    else $error("empty result item without word end");

  // H marks and the none marker never reach the output
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && digit_valid_o) |-> (code_digit_o <= 4'd8))
    else $error("code digit out of range");

  // a job is never pushed into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("job pushed while queue full");
`endif

endmodule
`default_nettype wire

// ----- rtl/cpe_front.sv -----
// Front end: takes word bytes, keeps look-back/held byte, codes raw symbols into jobs.
`timescale 1ns / 1ps
`default_nettype none
module cpe_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    letter_i,
  input  wire logic          word_end_i,
  input  wire logic          job_full_i,
  output logic               job_push_o,
  output cpe_pkg::job_t      job_o
);
  import cpe_pkg::*;

  logic [7:0] before_q, before_d;
  logic [7:0] held_q, held_d;
  logic       held_valid_q, held_valid_d;
  logic       held_first_q, held_first_d;

  logic [7:0] cur;
  logic       accept;
  raw_t       rh, rf;
  logic [1:0] hcnt, fcnt;
  logic [7:0] p_final;
  logic       first_final;

  assign in_stall_o = job_full_i;
  assign accept     = in_valid_i && !job_full_i;
  assign cur        = fold_upper(letter_i);

  assign p_final     = held_valid_q ? held_q : before_q;
  assign first_final = held_valid_q ? 1'b0 : held_first_q;

  always_comb begin
    rh   = raw_syms(before_q, held_q, cur, held_first_q);
    rf   = raw_syms(p_final, cur, SpaceChr, first_final);
    hcnt = held_valid_q ? rh.cnt : 2'd0;
    fcnt = word_end_i ? rf.cnt : 2'd0;

    job_o.sym      = '0;
    job_o.sym[0]   = rh.s0;
    job_o.sym[1]   = rh.s1;
    job_o.word_end = word_end_i;
    job_o.cnt      = {1'b0, hcnt} + {1'b0, fcnt};
    case (hcnt)
      2'd0: begin
        job_o.sym[0] = rf.s0;
        job_o.sym[1] = rf.s1;
      end
      2'd1: begin
        job_o.sym[1] = rf.s0;
        job_o.sym[2] = rf.s1;
      end
      2'd2: begin
        job_o.sym[2] = rf.s0;
        job_o.sym[3] = rf.s1;
      end
      default: ;
    endcase
    // a job with nothing to code and no word end has no effect downstream
    job_push_o = accept && (word_end_i || job_o.cnt != 3'd0);
  end

  always_comb begin
    before_d     = before_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    held_first_d = held_first_q;
    if (accept) begin
      if (word_end_i) begin
        before_d     = SpaceChr;
        held_d       = 8'h00;
        held_valid_d = 1'b0;
        held_first_d = 1'b1;
      end else begin
        if (held_valid_q) begin
          before_d     = held_q;
          held_first_d = 1'b0;
        end
        held_d       = cur;
        held_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q     <= SpaceChr;
      held_q       <= 8'h00;
      held_valid_q <= 1'b0;
      held_first_q <= 1'b1;
    end else begin
      before_q     <= before_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      held_first_q <= held_first_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cpe_fifo.sv -----
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module cpe_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cpe_pkg::job_t push_data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output cpe_pkg::job_t      pop_data_o
);
  import cpe_pkg::*;

  job_t       mem_q [FifoDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'(FifoDepth));
  assign valid_o    = (count_q != 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 2'd1;
    else if (!do_push && do_pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cpe_back.sv -----
// Back end: collapses runs, drops H marks and late zeros, streams digits out.
`timescale 1ns / 1ps
`default_nettype none
module cpe_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire cpe_pkg::job_t job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [3:0]         code_digit_o,
  output logic               digit_valid_o,
  output logic               word_done_o
);
  import cpe_pkg::*;

  // collapse history
  logic [3:0] last_q, last_d;
  logic       any_q, any_d;

  // digit buffer for the current job
  logic [JobSyms-1:0][3:0] dig_q, dig_d;
  logic [2:0] rem_q, rem_d;
  logic [1:0] idx_q, idx_d;
  logic       end_q, end_d;
  logic       blank_q, blank_d;

  // output register
  logic       ov_q;
  logic [3:0] ocode_q;
  logic       odv_q, odone_q;

  logic                    out_free, move, last_move, load;
  logic [JobSyms-1:0][3:0] surv;
  logic [2:0]              nsurv;
  logic [3:0]              f_last, s;
  logic                    f_any;

  assign out_free  = !ov_q || !out_stall_i;
  assign move      = (rem_q != 3'd0) && out_free;
  assign last_move = move && (rem_q == 3'd1);
  assign load      = job_valid_i && ((rem_q == 3'd0) || last_move);
  assign job_pop_o = load;

  // filter the job's raw symbols in order
  always_comb begin
    f_last = last_q;
    f_any  = any_q;
    surv   = '0;
    nsurv  = 3'd0;
    s      = 4'd0;
    for (int i = 0; i < JobSyms; i++) begin
      s = job_i.sym[i];
      if (3'(i) < job_i.cnt && s != f_last) begin
        f_last = s;
        if (s != SymHmark && !(s == 4'd0 && f_any)) begin
          f_any       = 1'b1;
          surv[nsurv[1:0]] = s;
          nsurv       = nsurv + 3'd1;
        end
      end
    end
  end

  always_comb begin
    last_d  = last_q;
    any_d   = any_q;
    dig_d   = dig_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    end_d   = end_q;
    blank_d = blank_q;
    if (load) begin
      dig_d   = surv;
      idx_d   = 2'd0;
      end_d   = job_i.word_end;
      blank_d = job_i.word_end && (nsurv == 3'd0);
      rem_d   = blank_d ? 3'd1 : nsurv;
      if (job_i.word_end) begin
        last_d = SymNone;
        any_d  = 1'b0;
      end else begin
        last_d = f_last;
        any_d  = f_any;
      end
    end else if (move) begin
      rem_d = rem_q - 3'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    idx_q   <= idx_d;
    end_q   <= end_d;
    blank_q <= blank_d;
    if (move) begin
      ocode_q <= blank_q ? 4'd0 : dig_q[idx_q];
      odv_q   <= !blank_q;
      odone_q <= end_q && (rem_q == 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= SymNone;
      any_q  <= 1'b0;
      rem_q  <= 3'd0;
      ov_q   <= 1'b0;
    end else begin
      last_q <= last_d;
      any_q  <= any_d;
      rem_q  <= rem_d;
      if (out_free) ov_q <= move;
    end
  end

  assign out_valid_o   = ov_q;
  assign code_digit_o  = ocode_q;
  assign digit_valid_o = odv_q;
  assign word_done_o   = odone_q;

endmodule
`default_nettype wire

// ----- tb/sv/cologne_phonetic_encoder_core_tb.sv -----
// Self-checking testbench for the Cologne phonetic encoder core, with a digit scoreboard.
`timescale 1ns / 1ps
module cologne_phonetic_encoder_core_tb;
  import cpe_pkg::SymHmark;
  import cpe_pkg::SymNone;
  import cpe_pkg::SpaceChr;

  localparam int unsigned NumBytes   = 170;
  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned TailCycles = 20;

  typedef struct packed {
    logic [3:0] digit;
    logic       valid;
    logic       done;
  } digit_req_t;

  // Predicts the digit stream and checks the output requests against it.
  class digit_scoreboard;
    logic [7:0] prev_byte;
    logic [7:0] held_byte;
    bit         held_ok;
    bit         held_first;
    logic [3:0] last_sym;
    bit         digit_out;
    digit_req_t digits_due[$];
    int         n_errors;
    int         n_checked;
    int         n_empty;
    int         n_words;

    function new();
      clear_word();
    endfunction

    function void clear_word();
      prev_byte  = SpaceChr;
      held_byte  = 8'h00;
      held_ok    = 1'b0;
      held_first = 1'b1;
      last_sym   = SymNone;
      digit_out  = 1'b0;
    endfunction

    function bit in_set(input logic [7:0] b, input string set);
      for (int i = 0; i < set.len(); i++) begin
        if (set[i] == b) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Raw symbols for byte c between p and n; returns how many (0..2).
    function int classify(input logic [7:0] p, input logic [7:0] c, input logic [7:0] n,
                          input bit first, output logic [3:0] s0, output logic [3:0] s1);
      s0 = 4'd0;
      s1 = 4'd0;
      if (first && c == "C") begin
        s0 = in_set(n, "AHKLOQRUX") ? 4'd4 : 4'd8;
        return 1;
      end
      if (c == "P" && n == "H") begin
        s0 = 4'd3;
        return 1;
      end
      if (c == "D" || c == "T") begin
        s0 = in_set(n, "SCZ") ? 4'd8 : 4'd2;
        return 1;
      end
      if (c == "X") begin
        if (in_set(p, "CKQ")) begin
          s0 = 4'd8;
          return 1;
        end
        s0 = 4'd4;
        s1 = 4'd8;
        return 2;
      end
      if (c == "C") begin
        if (p == "S" || p == "Z") s0 = 4'd8;
        else s0 = in_set(n, "AOUHKXQ") ? 4'd4 : 4'd8;
        return 1;
      end
      if (c == "H") begin
        s0 = SymHmark;
        return 1;
      end
      if (in_set(c, "AEIJYOU")) s0 = 4'd0;
      else if (c == "B" || c == "P") s0 = 4'd1;
      else if (in_set(c, "FVW")) s0 = 4'd3;
      else if (in_set(c, "GKQ")) s0 = 4'd4;
      else if (c == "L") s0 = 4'd5;
      else if (c == "R") s0 = 4'd7;
      else if (c == "M" || c == "N") s0 = 4'd6;
      else if (c == "S" || c == "Z") s0 = 4'd8;
      else return 0;
      return 1;
    endfunction

    // Run collapse, H mark removal and zero suppression on one byte's symbols.
    function void code_letter(input logic [7:0] p, input logic [7:0] c, input logic [7:0] n,
                              input bit first);
      logic [3:0] s0;
      logic [3:0] s1;
      logic [3:0] s;
      int         cnt;
      cnt = classify(p, c, n, first, s0, s1);
      for (int i = 0; i < cnt; i++) begin
        s = (i == 0) ? s0 : s1;
        if (s == last_sym) continue;
        last_sym = s;
        if (s == SymHmark) continue;
        if (s == 4'd0 && digit_out) continue;
        digit_out = 1'b1;
        digits_due.push_back('{digit: s, valid: 1'b1, done: 1'b0});
      end
    endfunction

    function void note_request(input logic [7:0] letter, input logic word_end);
      logic [7:0] cur;
      digit_req_t last;
      int         n_before;
      cur      = (letter >= "a" && letter <= "z") ? letter - 8'h20 : letter;
      n_before = digits_due.size();
      if (held_ok) begin
        code_letter(prev_byte, held_byte, cur, held_first);
        prev_byte  = held_byte;
        held_first = 1'b0;
      end
      held_byte = cur;
      held_ok   = 1'b1;
      if (word_end) begin
        code_letter(prev_byte, held_byte, SpaceChr, held_first);
        if (digits_due.size() == n_before) begin
          digits_due.push_back('{digit: 4'd0, valid: 1'b0, done: 1'b1});
        end else begin
          last      = digits_due.pop_back();
          last.done = 1'b1;
          digits_due.push_back(last);
        end
        n_words++;
        clear_word();
      end
    endfunction

    function void check_result(input logic [3:0] digit, input logic valid, input logic done);
      digit_req_t want;
      n_checked++;
      if (digits_due.size() == 0) begin
        $error("output request with no digit due: code_digit %0d digit_valid %0d word_done %0d",
               digit, valid, done);
        n_errors++;
        return;
      end
      want = digits_due.pop_front();
      if (!valid) n_empty++;
      if (digit !== want.digit) begin
        $error("code_digit: expected %0d, got %0d", want.digit, digit);
        n_errors++;
      end
      if (valid !== want.valid) begin
        $error("digit_valid: expected %0d, got %0d", want.valid, valid);
        n_errors++;
      end
      if (done !== want.done) begin
        $error("word_done: expected %0d, got %0d", want.done, done);
        n_errors++;
      end
    endfunction

    function int pending();
      return digits_due.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] letter_i;
  logic       word_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [3:0] code_digit_o;
  logic       digit_valid_o;
  logic       word_done_o;

  digit_scoreboard sb;
  int              n_sent;
  int              burst_left;
  int              idle_cycles;
  int              stall_mode;
  int              stall_left;
  int              stall_phase;

  cologne_phonetic_encoder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .letter_i     (letter_i),
    .word_end_i   (word_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_digit_o (code_digit_o),
    .digit_valid_o(digit_valid_o),
    .word_done_o  (word_done_o)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    letter_i    = 8'h00;
    word_end_i  = 1'b0;
    out_stall_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: switches between free-running, random, periodic and heavy stall stretches.
  initial begin
    stall_mode  = 0;
    stall_left  = 0;
    stall_phase = 0;
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 60);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_stall_i = 1'b0;
      1: out_stall_i = ($urandom_range(0, 2) == 0);
      2: out_stall_i = (stall_phase % 4 != 0);
      default: out_stall_i = ($urandom_range(0, 4) != 0);
    endcase
  end

  // Both channels are sampled at the rising edge; the watchdog counts edges with no transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(letter_i, word_end_i);
      if (out_valid_o && !out_stall_i) sb.check_result(code_digit_o, digit_valid_o, word_done_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no request moved for %0d cycles", IdleLimit);
        $display("cologne_phonetic_encoder_core: mismatch");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [7:0] letter, input logic word_end);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid_i = 1'b1;
    letter_i   = letter;
    word_end_i = word_end;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    burst_left--;
    n_sent++;
  endtask

  task automatic send_text(input string w);
    for (int i = 0; i < w.len(); i++) send_request(w[i], i == w.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Mostly letters, leaning on the context-dependent ones; some raw bytes.
  function automatic logic [7:0] pick_byte();
    string      heavy;
    string      soft_set;
    int         r;
    logic [7:0] b;
    heavy    = "CHXPDTSZKQ";
    soft_set = "AEIOUJYH";
    r        = $urandom_range(0, 99);
    if (r < 45) b = 8'h41 + 8'($urandom_range(0, 25));
    else if (r < 70) b = heavy[$urandom_range(0, heavy.len() - 1)];
    else if (r < 88) b = soft_set[$urandom_range(0, soft_set.len() - 1)];
    else b = 8'($urandom_range(0, 255));
    if (b >= "A" && b <= "Z" && $urandom_range(0, 1) == 1) b = b + 8'h20;
    return b;
  endfunction

  task automatic send_random_word();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) send_request(pick_byte(), i == len - 1);
  endtask

  initial begin
    bit paused;
    sb          = new();
    n_sent      = 0;
    burst_left  = 0;
    idle_cycles = 0;
    paused      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Initial C, X split, PH, D/T before sibilants, C after sibilant, H separator,
    // case folding at both ends of a-z, and words that yield no digit at all.
    send_text("CAX");
    send_text("phd");
    send_text("tzC");
    send_text("KX");
    send_text("aCU");
    send_text("CE");
    send_text("BHB");
    send_text("H");
    send_text("1");
    send_text("`{");
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b1);
    wait_drained();

    while (n_sent < NumBytes) begin
      send_random_word();
      if (!paused && n_sent > NumBytes / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    $display("run: %0d bytes in %0d words, %0d output requests checked (%0d empty word ends)",
             n_sent, sb.n_words, sb.n_checked, sb.n_empty);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("cologne_phonetic_encoder_core: match");
    end else begin
      $display("cologne_phonetic_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cpe_pkg.sv
rtl/cpe_front.sv
rtl/cpe_fifo.sv
rtl/cpe_back.sv
rtl/cologne_phonetic_encoder_core.sv
tb/sv/cologne_phonetic_encoder_core_tb.sv
